// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl, clocked on clk_i and muted while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DESM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DESM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/desm_pkg.sv
// ----------------------------------------------------------------------------
// desm_pkg
// Register map, field widths and reset values of the depth edge shard mask.
// ----------------------------------------------------------------------------
package desm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;

  localparam int GEOM_W  = 10;  // frame width and height registers
  localparam int DEPTH_W = 17;  // depth window bounds
  localparam int LIMIT_W = 36;  // squared distance limit
  localparam int IDX_W   = 18;  // pixel index on the result channel

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_DEPTH_MIN    = 3'd2,
    CFG_DEPTH_MAX    = 3'd3,
    CFG_DIST_LIMIT   = 3'd4
  } cfg_reg_e;

  localparam logic [GEOM_W-1:0]  FRAME_WIDTH_RST  = 10'd512;
  localparam logic [GEOM_W-1:0]  FRAME_HEIGHT_RST = 10'd424;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN_RST    = 17'd2000;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX_RST    = 17'd40000;
  localparam logic [LIMIT_W-1:0] DIST_LIMIT_RST   = 36'd1600;

endpackage

// File: rtl/desm_if.sv
// ----------------------------------------------------------------------------
// desm_if
// Valid/ready channels of the depth edge shard mask: points, results, config.
// ----------------------------------------------------------------------------
interface desm_in_if #(
  parameter int COORD_BITS = 18
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                  output ready);
endinterface

interface desm_out_if import desm_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] pixel_index;
  logic             shard;
  logic             run_last;

  modport source (output valid, output pixel_index, output shard, output run_last,
                  input ready);
  modport sink   (input valid, input pixel_index, input shard, input run_last,
                  output ready);
endinterface

interface desm_cfg_if import desm_pkg::*; ;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/depth_edge_shard_mask.sv
// ----------------------------------------------------------------------------
// depth_edge_shard_mask
// Flags out-of-range depths and edge shards in a raster stream of 3-D points.
// ----------------------------------------------------------------------------
// usage
//   in_i   : one point per transaction (coord_x/y/z, quarter mm), raster order
//   out_o  : one flag per transaction, pixel_index gives the judged point,
//            run_last marks the final result caused by one input point
//   cfg_i  : register writes, always ready, only while the block is idle
// a point is judged when the point one row below it arrives, so flags trail
// the input by one row; points of the last row also give their own flag
// registers: a result passes s1, s2 and the result register on its way to out_o
// throughput: one point per cycle while out_o takes every result; on the last
//   row each point gives two results, so the single result port holds the
//   input back there
// the line buffer is a two-read, one-write memory of MAX_WIDTH points with
//   registered read data; it needs no clearing after reset
// reset: counters return to row 0 column 0, registers to their defaults
// a stalled receiver backs pressure up the three register stages; nothing
//   is dropped and in_i.ready falls once all stages are full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module depth_edge_shard_mask import desm_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int COORD_BITS = 18
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  desm_cfg_if.sink     cfg_i,
  desm_in_if.sink      in_i,
  desm_out_if.source   out_o
);

  localparam int AW = $clog2(MAX_WIDTH);       // column index
  localparam int HW = $clog2(MAX_HEIGHT);      // row index
  localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int HH = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int RW = HW + WW;                 // row times width
  localparam int DW = COORD_BITS + 1;          // coordinate difference
  localparam int QW = 2 * DW;                  // squared difference
  localparam int SW = (QW + 5 > LIMIT_W) ? QW + 5 : LIMIT_W;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } point_t;

  typedef struct packed {
    logic has_prev;  // the point one row up is judged
    logic has_own;   // last row, the point itself is judged too
    logic inner;     // judged point is off the frame border
  } job_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [GEOM_W-1:0]  frame_width_q, frame_height_q;
  logic [DEPTH_W-1:0] depth_min_q, depth_max_q;
  logic [LIMIT_W-1:0] dist_limit_q;
  logic               cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
      depth_min_q    <= DEPTH_MIN_RST;
      depth_max_q    <= DEPTH_MAX_RST;
      dist_limit_q   <= DIST_LIMIT_RST;
    end else if (cfg_fire) begin
      case (cfg_reg_e'(cfg_i.index))
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_i.data[GEOM_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_i.data[GEOM_W-1:0];
        CFG_DEPTH_MIN:    depth_min_q    <= cfg_i.data[DEPTH_W-1:0];
        CFG_DEPTH_MAX:    depth_max_q    <= cfg_i.data[DEPTH_W-1:0];
        CFG_DIST_LIMIT:   dist_limit_q   <= cfg_i.data[LIMIT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // effective geometry: zero becomes one, width clamped to what the line buffer can hold, height to MAX_HEIGHT
  logic [WW-1:0] w;
  logic [HH-1:0] h;

  always_comb begin
    if (frame_width_q == '0) begin
      w = WW'(1);
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      h = HH'(1);
    end else if (32'(frame_height_q) > MAX_HEIGHT) begin
      h = HH'(MAX_HEIGHT);
    end else begin
      h = HH'(frame_height_q);
    end
  end

  // --------------------------------------------------------------------------
  // handshake chain: input -> s1 -> s2 -> result register
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q;
  logic hp_q, ho_q;  // pending result for the row above / for the point itself
  logic in_fire, out_fire, s1_ready, s2_ready, o_ready;

  assign out_fire   = out_o.valid && out_o.ready;
  // result register takes a new pair once it is empty or its last flag leaves
  assign o_ready    = !(hp_q || ho_q) || (out_fire && !(hp_q && ho_q));
  assign s2_ready   = !s2_valid_q || o_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign in_fire    = in_i.valid && s1_ready;

  // --------------------------------------------------------------------------
  // raster position
  // --------------------------------------------------------------------------
  logic [AW-1:0] col_q, col_d, c_cur, c_nxt;
  logic [HW-1:0] row_q, row_d, r_cur;
  logic [31:0]   r_wrap;
  logic          last_col, last_row;
  job_t          job;
  point_t        cur_pt;

  always_comb begin
    // counters beyond a newly written geometry restart before use
    c_cur  = col_q;
    r_wrap = 32'(row_q);
    if (32'(col_q) >= 32'(w)) begin
      c_cur  = '0;
      r_wrap = 32'(row_q) + 32'd1;
    end
    r_cur    = (r_wrap >= 32'(h)) ? '0 : HW'(r_wrap);
    last_col = (32'(c_cur) + 32'd1 >= 32'(w));
    last_row = (32'(r_cur) + 32'd1 == 32'(h));
    c_nxt    = last_col ? '0 : AW'(c_cur + AW'(1));

    col_d = last_col ? '0 : AW'(c_cur + AW'(1));
    row_d = r_cur;
    if (last_col) begin
      row_d = last_row ? '0 : HW'(r_cur + HW'(1));
    end

    job.has_prev = (r_cur != '0);
    job.has_own  = last_row;
    job.inner    = (r_cur > HW'(1)) && (c_cur != '0) && !last_col;

    cur_pt.x = in_i.coord_x;
    cur_pt.y = in_i.coord_y;
    cur_pt.z = in_i.coord_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_fire) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // s1: line buffer read of the point above and its right neighbour
  // --------------------------------------------------------------------------
  logic [$bits(point_t)-1:0] row_mem [MAX_WIDTH];

  point_t        s1_cur_q, s1_centre_q, s1_nbr_q;
  job_t          s1_job_q;
  logic [AW-1:0] s1_col_q;
  logic [HW-1:0] s1_row_q;

  // read before write: the entry at c_cur still holds the row above
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_centre_q   <= point_t'(row_mem[c_cur]);
      s1_nbr_q      <= point_t'(row_mem[c_nxt]);
      row_mem[c_cur] <= cur_pt;
      s1_cur_q      <= cur_pt;
      s1_job_q      <= job;
      s1_col_q      <= c_cur;
      s1_row_q      <= r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_fire;
    end
  end

  // --------------------------------------------------------------------------
  // s2: squared differences and depth window
  // --------------------------------------------------------------------------
  function automatic logic [QW-1:0] sq_diff(input logic signed [COORD_BITS-1:0] a,
                                            input logic signed [COORD_BITS-1:0] b);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        m;
    d = DW'(a) - DW'(b);
    m = d[DW-1] ? DW'(-d) : DW'(d);
    return QW'(m) * QW'(m);
  endfunction

  function automatic logic depth_out(input logic signed [COORD_BITS-1:0] z,
                                     input logic [DEPTH_W-1:0] lo,
                                     input logic [DEPTH_W-1:0] hi);
    logic signed [31:0] zs;
    zs = 32'(z);
    return (zs < $signed(32'(lo))) || (zs > $signed(32'(hi)));
  endfunction

  logic [QW-1:0] s2_nx_q, s2_ny_q, s2_nz_q;  // centre against right neighbour
  logic [QW-1:0] s2_bx_q, s2_by_q, s2_bz_q;  // centre against point below
  logic          s2_bad_centre_q, s2_bad_cur_q;
  logic [RW-1:0] s2_rw_q;
  logic [AW-1:0] s2_col_q;
  job_t          s2_job_q;

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_nx_q         <= sq_diff(s1_centre_q.x, s1_nbr_q.x);
      s2_ny_q         <= sq_diff(s1_centre_q.y, s1_nbr_q.y);
      s2_nz_q         <= sq_diff(s1_centre_q.z, s1_nbr_q.z);
      s2_bx_q         <= sq_diff(s1_centre_q.x, s1_cur_q.x);
      s2_by_q         <= sq_diff(s1_centre_q.y, s1_cur_q.y);
      s2_bz_q         <= sq_diff(s1_centre_q.z, s1_cur_q.z);
      s2_bad_centre_q <= depth_out(s1_centre_q.z, depth_min_q, depth_max_q);
      s2_bad_cur_q    <= depth_out(s1_cur_q.z, depth_min_q, depth_max_q);
      s2_rw_q         <= RW'(s1_row_q) * RW'(w);
      s2_col_q        <= s1_col_q;
      s2_job_q        <= s1_job_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // s3: distance and slope tests, result register
  // --------------------------------------------------------------------------
  function automatic logic pair_bad(input logic [QW-1:0] qx, input logic [QW-1:0] qy,
                                    input logic [QW-1:0] qz,
                                    input logic [LIMIT_W-1:0] lim);
    logic [SW-1:0] lat;
    logic [SW-1:0] lat9;
    logic [SW-1:0] dz;
    lat  = SW'(qx) + SW'(qy);
    dz   = SW'(qz);
    lat9 = (lat << 3) + lat;
    return (lat + dz > SW'(lim)) || (dz > lat9);
  endfunction

  logic             shard_prev, shard_own;
  logic [31:0]      own_sum, prev_sum;
  logic [IDX_W-1:0] prev_idx_q, own_idx_q;
  logic             prev_shard_q, own_shard_q;

  always_comb begin
    shard_prev = s2_bad_centre_q ||
                 (s2_job_q.inner &&
                  (pair_bad(s2_nx_q, s2_ny_q, s2_nz_q, dist_limit_q) ||
                   pair_bad(s2_bx_q, s2_by_q, s2_bz_q, dist_limit_q)));
    shard_own  = s2_bad_cur_q;
    own_sum    = 32'(s2_rw_q) + 32'(s2_col_q);
    prev_sum   = own_sum - 32'(w);
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && o_ready) begin
      prev_idx_q   <= prev_sum[IDX_W-1:0];
      own_idx_q    <= own_sum[IDX_W-1:0];
      prev_shard_q <= shard_prev;
      own_shard_q  <= shard_own;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_q <= 1'b0;
      ho_q <= 1'b0;
    end else begin
      if (out_fire) begin
        if (hp_q) begin
          hp_q <= 1'b0;
        end else begin
          ho_q <= 1'b0;
        end
      end
      // points of row 0 load an empty pair and drop out here, unless the frame is a single row
      if (s2_valid_q && o_ready) begin
        hp_q <= s2_job_q.has_prev;
        ho_q <= s2_job_q.has_own;
      end
    end
  end

  // the row above goes first, the point's own flag closes the transaction run
  assign out_o.valid       = hp_q || ho_q;
  assign out_o.pixel_index = hp_q ? prev_idx_q : own_idx_q;
  assign out_o.shard       = hp_q ? prev_shard_q : own_shard_q;
  assign out_o.run_last    = !(hp_q && ho_q);

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `DESM_ASSERT_NXT(a_pair_completes, out_fire && !out_o.run_last, out_o.valid && out_o.run_last, "second result of a pair missing")
  `DESM_ASSERT_NXT(a_pair_one_row_apart, out_fire && !out_o.run_last, out_o.pixel_index == IDX_W'($past(out_o.pixel_index) + IDX_W'(w)), "pair indices not one row apart")
  `DESM_ASSERT_IMP(a_stall_only_when_full, in_i.valid && !in_i.ready, s1_valid_q && s2_valid_q && (hp_q || ho_q), "input stalled with room in the pipeline")

endmodule

// File: test/shard_flag_checker.sv
// ----------------------------------------------------------------------------
// shard_flag_checker
// Watches the point, flag and register channels of the depth edge shard mask,
// predicts each flag from its own copy of the line buffer and registers, and
// compares every flag transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module shard_flag_checker import desm_pkg::*; #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int COORD_W    = 18
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  desm_cfg_if         cfg_i,
  desm_in_if          pts_i,
  desm_out_if         flags_i,
  output int unsigned pending_o,
  output int unsigned mismatch_o,
  output int unsigned checked_o
);

  localparam longint unsigned SLOPE_FACTOR = 9;  // depth step squared vs lateral step squared

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [IDX_W-1:0] pixel_index;
    logic             shard;
    logic             run_last;
  } shard_flag_t;

  point_t      line_buf [MAX_WIDTH];
  shard_flag_t flag_q [$];

  logic [GEOM_W-1:0]  width_reg;
  logic [GEOM_W-1:0]  height_reg;
  logic [DEPTH_W-1:0] depth_lo;
  logic [DEPTH_W-1:0] depth_hi;
  logic [LIMIT_W-1:0] dist_lim;
  int unsigned        col_cnt;
  int unsigned        row_cnt;
  int unsigned        mismatches;
  int unsigned        checked;

  function automatic longint unsigned sq_gap(input coord_t a, input coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d * d);
  endfunction

  function automatic logic depth_outside(input coord_t z);
    return (longint'(z) < longint'(depth_lo)) || (longint'(z) > longint'(depth_hi));
  endfunction

  function automatic logic pair_shard(input point_t p, input point_t q);
    longint unsigned lat;
    longint unsigned dz;
    longint unsigned lim;
    lat = sq_gap(p.x, q.x) + sq_gap(p.y, q.y);
    dz  = sq_gap(p.z, q.z);
    lim = {{(64-LIMIT_W){1'b0}}, dist_lim};
    return (lat + dz > lim) || (dz > lat * SLOPE_FACTOR);
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    case (cfg_reg_e'(idx))
      CFG_FRAME_WIDTH:  width_reg  = val[GEOM_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = val[GEOM_W-1:0];
      CFG_DEPTH_MIN:    depth_lo   = val[DEPTH_W-1:0];
      CFG_DEPTH_MAX:    depth_hi   = val[DEPTH_W-1:0];
      CFG_DIST_LIMIT:   dist_lim   = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // expected flags wait here in arrival order
  task automatic queue_flag(input shard_flag_t f);
    flag_q = {flag_q, f};
  endtask

  task automatic predict_flags(input point_t here);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    point_t           centre;
    logic             flag;
    logic [IDX_W-1:0] idx;
    w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt >= h) row_cnt = 0;
    c = col_cnt;
    r = row_cnt;
    // the point one row up is judged now that its lower neighbour is here
    if (r >= 1) begin
      centre = line_buf[c];
      flag   = depth_outside(centre.z);
      if (!flag && c != 0 && c + 1 != w && r - 1 != 0) begin
        flag = pair_shard(centre, line_buf[c + 1]) || pair_shard(centre, here);
      end
      idx = IDX_W'((r - 1) * w + c);
      queue_flag('{pixel_index: idx, shard: flag, run_last: (r + 1 != h)});
    end
    line_buf[c] = here;
    // last row: own flag, depth only
    if (r + 1 == h) begin
      idx = IDX_W'(r * w + c);
      queue_flag('{pixel_index: idx, shard: depth_outside(here.z), run_last: 1'b1});
    end
    col_cnt = c + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end
  endtask

  task automatic compare_flag(input shard_flag_t got);
    shard_flag_t want;
    if (flag_q.size() == 0) begin
      $display("%0t flag with no prediction: pixel_index %0d shard %0b run_last %0b",
               $time, got.pixel_index, got.shard, got.run_last);
      mismatches++;
      return;
    end
    want = flag_q.pop_front();
    checked++;
    if (got.pixel_index !== want.pixel_index) begin
      $display("%0t pixel_index mismatch: expected %0d, actual %0d",
               $time, want.pixel_index, got.pixel_index);
      mismatches++;
    end
    if (got.shard !== want.shard) begin
      $display("%0t shard mismatch at pixel %0d: expected %0b, actual %0b",
               $time, want.pixel_index, want.shard, got.shard);
      mismatches++;
    end
    if (got.run_last !== want.run_last) begin
      $display("%0t run_last mismatch at pixel %0d: expected %0b, actual %0b",
               $time, want.pixel_index, want.run_last, got.run_last);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      depth_lo   = DEPTH_MIN_RST;
      depth_hi   = DEPTH_MAX_RST;
      dist_lim   = DIST_LIMIT_RST;
      col_cnt    = 0;
      row_cnt    = 0;
      mismatches = 0;
      checked    = 0;
      flag_q.delete();
      pending_o  <= 0;
      mismatch_o <= 0;
      checked_o  <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) apply_reg(cfg_i.index, cfg_i.data);
      if (pts_i.valid && pts_i.ready) begin
        predict_flags('{x: pts_i.coord_x, y: pts_i.coord_y, z: pts_i.coord_z});
      end
      if (flags_i.valid && flags_i.ready) begin
        compare_flag('{pixel_index: flags_i.pixel_index, shard: flags_i.shard,
                       run_last: flags_i.run_last});
      end
      pending_o  <= flag_q.size();
      mismatch_o <= mismatches;
      checked_o  <= checked;
    end
  end

endmodule

// File: test/depth_edge_shard_mask_tb.sv
// ----------------------------------------------------------------------------
// depth_edge_shard_mask_tb
// Drives raster frames of 3-D points into the depth edge shard mask under
// varying frame geometry, depth windows and distance limits, with random
// idling on both sides; a separate checker predicts and compares every flag.
// ----------------------------------------------------------------------------
module depth_edge_shard_mask_tb;
  import desm_pkg::*;

  localparam int COORD_W       = 18;
  localparam int MAX_WIDTH     = 512;
  localparam int MAX_HEIGHT    = 512;
  localparam int COORD_MAX     = 2 ** (COORD_W - 1) - 1;
  localparam int COORD_MIN     = -(2 ** (COORD_W - 1));
  localparam int SETTLE_CYCLES = 8;       // quiet time after the last expected flag
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_POINTS = 1650;
  localparam int MIN_FRAMES    = 12;

  // a register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

  localparam logic [DEPTH_W-1:0] DEPTH_TOP = {DEPTH_W{1'b1}};
  localparam logic [LIMIT_W-1:0] LIMIT_TOP = {LIMIT_W{1'b1}};

  typedef logic signed [COORD_W-1:0] coord_t;

  logic clk;
  logic rst_n;

  desm_in_if #(.COORD_BITS(COORD_W)) pts_if ();
  desm_out_if                        flag_if ();
  desm_cfg_if                        cfg_if ();

  int unsigned flags_pending;
  int unsigned mismatch_count;
  int unsigned flags_checked;

  int idle_pct;      // chance of a sender gap before each point
  int stall_pct;     // chance of the receiver holding ready low in a cycle
  int points_sent;
  int frames_sent;
  int cycle_count;

  depth_edge_shard_mask #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COORD_BITS (COORD_W)
  ) DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (pts_if),
    .out_o  (flag_if)
  );

  shard_flag_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COORD_W    (COORD_W)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_i      (cfg_if),
    .pts_i      (pts_if),
    .flags_i    (flag_if),
    .pending_o  (flags_pending),
    .mismatch_o (mismatch_count),
    .checked_o  (flags_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d flags still expected", cycle_count, flags_pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: ready drawn afresh every cycle
  initial begin
    flag_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      flag_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic coord_t clip_coord(input int v);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    return coord_t'(v);
  endfunction

  function automatic int clamp_geom(input int v, input int top);
    return (v < 1) ? 1 : ((v > top) ? top : v);
  endfunction

  // one point transaction; valid is left high for a following point
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z);
    while ($urandom_range(99) < idle_pct) begin
      pts_if.valid <= 1'b0;
      @(posedge clk);
    end
    pts_if.valid   <= 1'b1;
    pts_if.coord_x <= x;
    pts_if.coord_y <= y;
    pts_if.coord_z <= z;
    do @(posedge clk); while (!pts_if.ready);
    points_sent++;
  endtask

  // stop sending and wait until every predicted flag has come back
  task automatic drain_flags();
    pts_if.valid <= 1'b0;
    do @(posedge clk); while (flags_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  // whole register set, written back to back while the block is idle
  task automatic set_regs(input int fw, input int fh, input logic [DEPTH_W-1:0] lo,
                          input logic [DEPTH_W-1:0] hi, input logic [LIMIT_W-1:0] lim,
                          input logic spare);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(fw));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(fh));
    write_reg(CFG_DEPTH_MIN, CFG_DATA_W'(lo));
    write_reg(CFG_DEPTH_MAX, CFG_DATA_W'(hi));
    write_reg(CFG_DIST_LIMIT, CFG_DATA_W'(lim));
    // writes to an unmapped index must leave every register alone
    if (spare) write_reg(CFG_IDX_SPARE, CFG_DATA_W'({$urandom, $urandom}));
    cfg_if.valid <= 1'b0;
  endtask

  // one or more whole frames of random content; geometry only ever changes
  // on a frame boundary so every line buffer read used for a flag finds a written entry
  task automatic run_frame(input int mode, input int fw, input int fh, input logic pause);
    int                 weff;
    int                 heff;
    int                 total;
    int                 r;
    int                 c;
    int                 bx;
    int                 by;
    int                 bz;
    int                 pitch;
    int                 slope;
    int                 jit;
    int                 zv;
    int                 roll;
    logic               noisy;
    logic [DEPTH_W-1:0] lo;
    logic [DEPTH_W-1:0] hi;
    logic [LIMIT_W-1:0] lim;
    coord_t             x;
    coord_t             y;
    coord_t             z;
    weff = clamp_geom(fw, MAX_WIDTH);
    heff = clamp_geom(fh, MAX_HEIGHT);
    total = weff * heff;
    if (total < 8) total = total * 4;
    // depth window: default, widest, inverted, or random
    case ($urandom_range(5))
      1:       begin lo = '0; hi = DEPTH_TOP; end
      2:       begin
        lo = DEPTH_TOP - DEPTH_W'($urandom_range(60000));
        hi = DEPTH_W'($urandom_range(60000));
      end
      3:       begin
        lo = DEPTH_W'($urandom_range(60000));
        hi = DEPTH_W'(int'(lo) + $urandom_range(70000));
      end
      default: begin lo = DEPTH_MIN_RST; hi = DEPTH_MAX_RST; end
    endcase
    case ($urandom_range(5))
      0:       lim = '0;
      1:       lim = LIMIT_TOP;
      2, 3:    lim = DIST_LIMIT_RST;
      default: lim = LIMIT_W'($urandom_range(50, 50000));
    endcase
    set_regs(fw, fh, lo, hi, lim, ($urandom_range(3) == 0));
    idle_pct  = (mode == 1) ? 69 : ((mode == 3) ? 15 : 0);
    stall_pct = (mode == 2) ? 69 : ((mode == 3) ? 15 : 0);
    noisy = ($urandom_range(4) == 0);
    // a smooth tilted surface with a little jitter, now and then a depth step or a random depth
    bx    = int'($urandom_range(200000)) - 100000;
    by    = int'($urandom_range(200000)) - 100000;
    bz    = (lo <= hi) ? int'(lo) + int'($urandom_range(int'(hi) - int'(lo)))
                       : int'($urandom_range(COORD_MAX));
    pitch = $urandom_range(2, 25);
    slope = int'($urandom_range(6)) - 3;
    jit   = $urandom_range(15);
    for (int k = 0; k < total; k++) begin
      r = (k / weff) % heff;
      c = k % weff;
      if (pause && k == total / 2) drain_flags();
      if (noisy) begin
        x = coord_t'($urandom);
        y = coord_t'($urandom);
        z = coord_t'($urandom);
      end else begin
        x  = clip_coord(bx + c * pitch + int'($urandom_range(2 * jit)) - jit);
        y  = clip_coord(by + r * pitch + int'($urandom_range(2 * jit)) - jit);
        zv = bz + slope * c + int'($urandom_range(2 * jit)) - jit;
        roll = $urandom_range(99);
        if (roll < 4) begin
          zv = zv + (($urandom_range(1) != 0) ? 1 : -1) * int'($urandom_range(50, 20000));
        end
        z = (roll >= 4 && roll < 7) ? coord_t'($urandom) : clip_coord(zv);
      end
      send_point(x, y, z);
    end
    drain_flags();
    frames_sent++;
  endtask

  initial begin
    int directed_pts;
    int f;
    int fw;
    int fh;
    pts_if.valid   = 1'b0;
    pts_if.coord_x = '0;
    pts_if.coord_y = '0;
    pts_if.coord_z = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    rst_n          = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    points_sent    = 0;
    frames_sent    = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4x3 frame, depth window edges and the strict comparisons
    // sitting exactly on the distance limit and on the nine-times slope
    set_regs(4, 3, DEPTH_MIN_RST, DEPTH_MAX_RST, DIST_LIMIT_RST, 1'b0);
    send_point(0, 0, 1999);
    send_point(10, 0, 2000);
    send_point(20, 0, 40000);
    send_point(30, 0, 40001);
    send_point(0, 10, 5000);
    send_point(10, 10, 5000);
    send_point(20, 10, 5030);
    send_point(30, 10, 5030);
    send_point(0, 20, coord_t'(COORD_MIN));
    send_point(10, 20, 5000);
    send_point(20, 50, 5030);
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MIN), coord_t'(COORD_MAX));
    // next frame, same geometry, one step past each limit: slope just too steep, neighbour just too far
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MAX), -1);
    send_point(0, 0, 0);
    send_point(0, 0, coord_t'(COORD_MAX));
    send_point(-1, -1, 2000);
    send_point(0, 10, 5000);
    send_point(10, 10, 5000);
    send_point(20, 10, 5031);
    send_point(30, 10, 5031);
    send_point(0, 20, 5000);
    send_point(10, 20, 5000);
    send_point(20, 51, 5031);
    send_point(30, 20, 5031);
    drain_flags();
    // zero width and height clamp to a single point frame; unmapped index write
    set_regs(0, 0, '0, DEPTH_TOP, LIMIT_TOP, 1'b1);
    send_point(coord_t'(COORD_MAX), coord_t'(COORD_MAX), coord_t'(COORD_MAX));
    send_point(coord_t'(COORD_MIN), coord_t'(COORD_MIN), coord_t'(COORD_MIN));
    drain_flags();
    directed_pts = points_sent;

    // random frames, cycling through the pacing modes; one full-width frame
    // with an oversized width, one single-column frame of maximum height
    f = 0;
    while (!(points_sent - directed_pts >= RANDOM_POINTS && f >= MIN_FRAMES)) begin
      if (f == 1) begin
        fw = 1023;
        fh = 2;
      end else if (f == 6) begin
        fw = 1;
        fh = 1023;
      end else begin
        fw = $urandom_range(1, 9);
        fh = $urandom_range(1, 6);
        if ($urandom_range(19) == 0) fw = 0;
        if ($urandom_range(19) == 0) fh = 0;
      end
      run_frame(f % 4, fw, fh, (f == 4));
      f++;
    end

    $display("%0d points in %0d random frames plus directed frames, %0d flags checked",
             points_sent, frames_sent, flags_checked);
    $display("geometry 1x1 up to 512 wide and 512 tall, inverted and full depth windows, "
             , "zero and full distance limits, four pacing modes");
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/desm_pkg.sv
rtl/desm_if.sv
rtl/depth_edge_shard_mask.sv
test/shard_flag_checker.sv
test/depth_edge_shard_mask_tb.sv
